>>> sv/sgw_pkg.sv
// Shared types, register codes and constants of the super-Gaussian weight block.
`timescale 1ns / 1ps
`default_nettype none

package sgw_pkg;

  // Default width of one coordinate.
  localparam int COORD_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_ANGLE     = 3'd0,
    REG_SIN_ANGLE     = 3'd1,
    REG_GAIN_X        = 3'd2,
    REG_GAIN_Y        = 3'd3,
    REG_HALF_EXPONENT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [17:0] cos_angle;
    logic [17:0] sin_angle;
    logic [31:0] gain_x;
    logic [31:0] gain_y;
    logic [15:0] half_exponent;
  } cfg_t;

  localparam logic [17:0] COS_RESET      = 18'd65536;
  localparam logic [17:0] SIN_RESET      = 18'd0;
  localparam logic [31:0] GAIN_RESET     = 32'd65536;
  localparam logic [15:0] HALF_EXP_RESET = 16'd4096;

  // Widths of the values passed between the parts.
  localparam int R2_W     = 32;
  localparam int WEIGHT_W = 16;

  // Queue depths (powers of two).
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Squaring steps of the log2 and the exp2 polynomial, ln2^n/n! in Q30.
  localparam int LOG_ITER   = 16;
  localparam int EXP2_TERMS = 8;
  localparam logic [31:0] EXP2_COEF [EXP2_TERMS] = '{
    32'd1073741824, 32'd744261118, 32'd257941247, 32'd59597083,
    32'd10327387,   32'd1431680,   32'd165394,    32'd16378
  };

  // log2(e) in Q30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // Sideband carried through each polynomial pipeline.
  localparam int POLY_SIDE_W = 9;

endpackage

`default_nettype wire

>>> sv/sgw_fifo.sv
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none

module sgw_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  output logic             full,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

>>> sv/sgw_front.sv
// Front part: rotates each point and forms the saturated elliptical squared radius.
`timescale 1ns / 1ps
`default_nettype none

module sgw_front #(
  parameter int COORD_BITS = sgw_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire sgw_pkg::cfg_t           cfg,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire  [COORD_BITS-1:0]        in_x_pos,
  input  wire  [COORD_BITS-1:0]        in_y_pos,
  output logic                         mid_push,
  input  wire                          mid_full,
  output logic [sgw_pkg::R2_W-1:0]     mid_r2
);

  localparam int STAGES = 8;
  localparam int PW     = COORD_BITS + 18;
  localparam int SW     = PW + 1;

  logic en;
  logic vld_r [STAGES];

  // Stage 1: products of the rotation.
  logic signed [PW-1:0] cx_r, sy_r, cy_r, sx_r;
  // Stage 2: rotated coordinates.
  logic [SW-1:0] xr_r, yr_r;
  // Stage 3: magnitudes split into 18-bit halves.
  logic        big3_x_r, big3_y_r;
  logic [17:0] th_x_r, tl_x_r, th_y_r, tl_y_r;
  // Stage 4: partial squares.
  logic        big4_x_r, big4_y_r;
  logic [35:0] hh_x_r, hl_x_r, ll_x_r, hh_y_r, hl_y_r, ll_y_r;
  // Stage 5: full squares.
  logic        big5_x_r, big5_y_r;
  logic [71:0] t2_x_r, t2_y_r;
  // Stage 6: gain partial products.
  logic        sat6_x_r, sat6_y_r;
  logic [55:0] pc0_x_r, pc1_x_r, pc2_x_r, pc0_y_r, pc1_y_r, pc2_y_r;
  // Stage 7: axis terms, saturated at 2^32.
  logic [32:0] term_x_r, term_y_r;
  // Stage 8: squared radius.
  logic [31:0] r2_r;

  logic [SW-1:0]  mag_x, mag_y;
  logic [63:0]    t64_x, t64_y;
  logic [103:0]   p_x, p_y;
  logic [32:0]    term_x_nxt, term_y_nxt;
  logic [33:0]    sum;
  logic [31:0]    r2_nxt;

  assign en       = !(vld_r[STAGES-1] && mid_full);
  assign in_full  = !en;
  assign mid_push = vld_r[STAGES-1] && !mid_full;
  assign mid_r2   = r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_push;
      for (int i = 1; i < STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    mag_x = xr_r[SW-1] ? (SW'(0) - xr_r) : xr_r;
    mag_y = yr_r[SW-1] ? (SW'(0) - yr_r) : yr_r;
    t64_x = 64'(mag_x);
    t64_y = 64'(mag_y);

    p_x = (104'(pc2_x_r) << 48) + (104'(pc1_x_r) << 24) + 104'(pc0_x_r);
    p_y = (104'(pc2_y_r) << 48) + (104'(pc1_y_r) << 24) + 104'(pc0_y_r);
    term_x_nxt = (sat6_x_r || (|p_x[103:72])) ? 33'h1_0000_0000 : {1'b0, p_x[71:40]};
    term_y_nxt = (sat6_y_r || (|p_y[103:72])) ? 33'h1_0000_0000 : {1'b0, p_y[71:40]};

    sum    = 34'(term_x_r) + 34'(term_y_r);
    r2_nxt = (|sum[33:32]) ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= PW'($signed(cfg.cos_angle)) * PW'($signed(in_x_pos));
      sy_r <= PW'($signed(cfg.sin_angle)) * PW'($signed(in_y_pos));
      cy_r <= PW'($signed(cfg.cos_angle)) * PW'($signed(in_y_pos));
      sx_r <= PW'($signed(cfg.sin_angle)) * PW'($signed(in_x_pos));

      xr_r <= {cx_r[PW-1], cx_r} + {sy_r[PW-1], sy_r};
      yr_r <= {cy_r[PW-1], cy_r} - {sx_r[PW-1], sx_r};

      big3_x_r <= |t64_x[63:36];
      big3_y_r <= |t64_y[63:36];
      th_x_r   <= t64_x[35:18];
      tl_x_r   <= t64_x[17:0];
      th_y_r   <= t64_y[35:18];
      tl_y_r   <= t64_y[17:0];

      big4_x_r <= big3_x_r;
      big4_y_r <= big3_y_r;
      hh_x_r   <= 36'(th_x_r) * 36'(th_x_r);
      hl_x_r   <= 36'(th_x_r) * 36'(tl_x_r);
      ll_x_r   <= 36'(tl_x_r) * 36'(tl_x_r);
      hh_y_r   <= 36'(th_y_r) * 36'(th_y_r);
      hl_y_r   <= 36'(th_y_r) * 36'(tl_y_r);
      ll_y_r   <= 36'(tl_y_r) * 36'(tl_y_r);

      big5_x_r <= big4_x_r;
      big5_y_r <= big4_y_r;
      t2_x_r   <= (72'(hh_x_r) << 36) + (72'(hl_x_r) << 19) + 72'(ll_x_r);
      t2_y_r   <= (72'(hh_y_r) << 36) + (72'(hl_y_r) << 19) + 72'(ll_y_r);

      // A square of 2^72 or more overflows the term unless the gain is zero.
      sat6_x_r <= big5_x_r && (|cfg.gain_x);
      sat6_y_r <= big5_y_r && (|cfg.gain_y);
      pc0_x_r  <= 56'(cfg.gain_x) * 56'(t2_x_r[23:0]);
      pc1_x_r  <= 56'(cfg.gain_x) * 56'(t2_x_r[47:24]);
      pc2_x_r  <= 56'(cfg.gain_x) * 56'(t2_x_r[71:48]);
      pc0_y_r  <= 56'(cfg.gain_y) * 56'(t2_y_r[23:0]);
      pc1_y_r  <= 56'(cfg.gain_y) * 56'(t2_y_r[47:24]);
      pc2_y_r  <= 56'(cfg.gain_y) * 56'(t2_y_r[71:48]);

      term_x_r <= term_x_nxt;
      term_y_r <= term_y_nxt;

      r2_r <= r2_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/sgw_horner.sv
// Seven-step pipelined Horner evaluation of the exp2 polynomial in Q30.
`timescale 1ns / 1ps
`default_nettype none

module sgw_horner #(
  parameter int SIDE_W = 1
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_v,
  input  wire  [15:0]       in_f,
  input  wire  [SIDE_W-1:0] in_side,
  output logic              out_v,
  output logic [31:0]       out_acc,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = sgw_pkg::EXP2_TERMS - 1;

  logic              v_r    [STEPS];
  logic [31:0]       acc_r  [STEPS];
  logic [15:0]       f_r    [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  logic [31:0] acc_in  [STEPS];
  logic [15:0] f_in    [STEPS];
  logic [47:0] prod    [STEPS];
  logic [31:0] acc_nxt [STEPS];

  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      acc_in[j]  = (j == 0) ? sgw_pkg::EXP2_COEF[STEPS] : acc_r[(j == 0) ? 0 : j-1];
      f_in[j]    = (j == 0) ? in_f : f_r[(j == 0) ? 0 : j-1];
      prod[j]    = 48'(acc_in[j]) * 48'(f_in[j]);
      acc_nxt[j] = sgw_pkg::EXP2_COEF[3'(STEPS-1-j)] + prod[j][47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STEPS; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int j = 1; j < STEPS; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int j = 1; j < STEPS; j++) side_r[j] <= side_r[j-1];
      for (int j = 0; j < STEPS; j++) begin
        acc_r[j] <= acc_nxt[j];
        f_r[j]   <= f_in[j];
      end
    end
  end

  assign out_v    = v_r[STEPS-1];
  assign out_acc  = acc_r[STEPS-1];
  assign out_side = side_r[STEPS-1];

endmodule

`default_nettype wire

>>> sv/sgw_back.sv
// Back part: log2 of the squared radius, power, exp2 chain and the final weight.
`timescale 1ns / 1ps
`default_nettype none

module sgw_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire sgw_pkg::cfg_t               cfg,
  input  wire                              mid_empty,
  output logic                             mid_pop,
  input  wire  [sgw_pkg::R2_W-1:0]         mid_r2,
  input  wire                              out_full,
  output logic                             out_push,
  output logic [sgw_pkg::WEIGHT_W-1:0]     out_weight
);

  localparam int LI = sgw_pkg::LOG_ITER;
  localparam int SW = sgw_pkg::POLY_SIDE_W;

  logic en;

  // Normalization of the squared radius.
  logic [31:0] norm;
  logic [4:0]  lz;

  // log2 pipeline: index 0 holds the normalized mantissa.
  logic        lg_v_r    [LI+1];
  logic [31:0] lg_m_r    [LI+1];
  logic [15:0] lg_fr_r   [LI+1];
  logic [4:0]  lg_msb_r  [LI+1];
  logic        lg_zero_r [LI+1];
  logic [63:0] lg_sq     [LI];
  logic [32:0] lg_m2     [LI];

  // Power stage.
  logic signed [21:0] log_val;
  logic               pr_v_r, pr_zero_r;
  logic signed [37:0] pr_r;

  // Exponent split stage.
  logic signed [25:0] e_val;
  logic signed [9:0]  e_int;
  logic               ex_v_r;
  logic [15:0]        ex_f_r;
  logic [SW-1:0]      ex_side_r;

  // First polynomial.
  logic          h1_v;
  logic [31:0]   h1_acc;
  logic [SW-1:0] h1_side;

  // Shifted power and scaled power.
  logic        sp_v_r, sp_frc_r, sp_one_r;
  logic [19:0] sp_p_r;
  logic [50:0] vv_prod;
  logic        vv_v_r, vv_frc_r, vv_one_r;
  logic [20:0] vv_r;
  logic        vf_zero;
  logic [5:0]  sh2;

  // Second polynomial.
  logic          h2_v;
  logic [31:0]   h2_acc;
  logic [SW-1:0] h2_side;

  // Final weight.
  logic        f_v_r;
  logic [15:0] f_w_r;
  logic [31:0] g_val, g_shift;
  logic [15:0] w_nxt;

  assign en         = !(f_v_r && out_full);
  assign mid_pop    = en && !mid_empty;
  assign out_push   = f_v_r && !out_full;
  assign out_weight = f_w_r;

  // Leading-zero count in five halving steps.
  always_comb begin
    norm = mid_r2;
    lz   = '0;
    if (norm[31:16] == '0) begin
      norm  = norm << 16;
      lz[4] = 1'b1;
    end
    if (norm[31:24] == '0) begin
      norm  = norm << 8;
      lz[3] = 1'b1;
    end
    if (norm[31:28] == '0) begin
      norm  = norm << 4;
      lz[2] = 1'b1;
    end
    if (norm[31:30] == '0) begin
      norm  = norm << 2;
      lz[1] = 1'b1;
    end
    if (!norm[31]) begin
      norm  = norm << 1;
      lz[0] = 1'b1;
    end
  end

  // Each log step squares the Q1.31 mantissa and takes one fraction bit.
  always_comb begin
    for (int k = 0; k < LI; k++) begin
      lg_sq[k] = 64'(lg_m_r[k]) * 64'(lg_m_r[k]);
      lg_m2[k] = lg_sq[k][63:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LI; k++) lg_v_r[k] <= 1'b0;
    end else if (en) begin
      lg_v_r[0] <= !mid_empty;
      for (int k = 1; k <= LI; k++) lg_v_r[k] <= lg_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m_r[0]    <= norm;
      lg_fr_r[0]   <= '0;
      lg_msb_r[0]  <= 5'd31 - lz;
      lg_zero_r[0] <= (mid_r2 == '0);
      for (int k = 1; k <= LI; k++) begin
        lg_m_r[k]    <= lg_m2[k-1][32] ? lg_m2[k-1][32:1] : lg_m2[k-1][31:0];
        lg_fr_r[k]   <= {lg_fr_r[k-1][14:0], lg_m2[k-1][32]};
        lg_msb_r[k]  <= lg_msb_r[k-1];
        lg_zero_r[k] <= lg_zero_r[k-1];
      end
    end
  end

  assign log_val = $signed({6'({1'b0, lg_msb_r[LI]} - 6'd24), lg_fr_r[LI]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
      ex_v_r <= 1'b0;
      sp_v_r <= 1'b0;
      vv_v_r <= 1'b0;
      f_v_r  <= 1'b0;
    end else if (en) begin
      pr_v_r <= lg_v_r[LI];
      ex_v_r <= pr_v_r;
      sp_v_r <= h1_v;
      vv_v_r <= sp_v_r;
      f_v_r  <= h2_v;
    end
  end

  // Floor division by 4096 is the arithmetic shift; the integer part is a floor too.
  assign e_val = pr_r[37:12];
  assign e_int = e_val[25:16];

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r      <= 38'($signed({1'b0, cfg.half_exponent})) * 38'(log_val);
      pr_zero_r <= lg_zero_r[LI];

      ex_f_r    <= e_val[15:0];
      // Side: shift, shift beyond 63, forced result, forced result is one.
      ex_side_r <= {6'(10'sd14 - e_int),
                    (e_int < -10'sd49),
                    pr_zero_r || (!e_val[25] && (|e_val[24:18])),
                    pr_zero_r};
    end
  end

  sgw_horner #(
    .SIDE_W (SW)
  ) u_pow_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (ex_v_r),
    .in_f     (ex_f_r),
    .in_side  (ex_side_r),
    .out_v    (h1_v),
    .out_acc  (h1_acc),
    .out_side (h1_side)
  );

  assign vv_prod = 51'(sp_p_r) * 51'(sgw_pkg::LOG2E_Q30);
  assign vf_zero = (vv_r[15:0] == '0);
  assign sh2     = 6'(vv_r[20:16]) + 6'd14 + 6'(!vf_zero);

  always_ff @(posedge clk) begin
    if (en) begin
      sp_p_r   <= h1_side[2] ? 20'd0 : 20'(h1_acc >> h1_side[8:3]);
      sp_frc_r <= h1_side[1];
      sp_one_r <= h1_side[0];

      vv_r     <= vv_prod[50:30];
      vv_frc_r <= sp_frc_r;
      vv_one_r <= sp_one_r;
    end
  end

  sgw_horner #(
    .SIDE_W (SW)
  ) u_exp_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vv_v_r),
    .in_f     (16'd0 - vv_r[15:0]),
    .in_side  ({sh2, vf_zero, vv_frc_r, vv_one_r}),
    .out_v    (h2_v),
    .out_acc  (h2_acc),
    .out_side (h2_side)
  );

  always_comb begin
    g_val   = h2_side[2] ? 32'h4000_0000 : h2_acc;
    g_shift = g_val >> h2_side[8:3];
    w_nxt   = (|g_shift[31:16]) ? 16'hFFFF : g_shift[15:0];
    if (h2_side[1]) begin
      w_nxt = h2_side[0] ? 16'hFFFF : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) f_w_r <= w_nxt;
  end

endmodule

`default_nettype wire

>>> sv/super_gaussian_weight.sv
// Top level of the super-Gaussian beam weight block: registers, front, queues and back.
// Pipeline: the front takes 8 stages and the back 36.
// Throughput: one point per cycle; each pipeline stalls as a whole only while its
// outgoing queue is full. Reset is synchronous and active low; it empties both
// queues and all pipelines and returns the registers to their documented values.
`timescale 1ns / 1ps
`default_nettype none

module super_gaussian_weight #(
  parameter int COORD_BITS = sgw_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Point input queue side.
  input  wire                               in_push,
  output logic                              in_full,
  input  wire  [COORD_BITS-1:0]             in_x_pos,
  input  wire  [COORD_BITS-1:0]             in_y_pos,
  // Weight output queue side.
  output logic                              out_empty,
  input  wire                               out_pop,
  output logic [sgw_pkg::WEIGHT_W-1:0]      out_weight,
  // Register write channel.
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [sgw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sgw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sgw_pkg::cfg_t cfg_r, cfg_nxt;

  logic                         mid_push, mid_full, mid_pop, mid_empty;
  logic [sgw_pkg::R2_W-1:0]     front_r2, mid_r2;
  logic                         res_push, res_full;
  logic [sgw_pkg::WEIGHT_W-1:0] res_weight;

  // Registers accept a transfer in every cycle; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (sgw_pkg::cfg_reg_t'(cfg_index))
        sgw_pkg::REG_COS_ANGLE:     cfg_nxt.cos_angle     = cfg_data[17:0];
        sgw_pkg::REG_SIN_ANGLE:     cfg_nxt.sin_angle     = cfg_data[17:0];
        sgw_pkg::REG_GAIN_X:        cfg_nxt.gain_x        = cfg_data[31:0];
        sgw_pkg::REG_GAIN_Y:        cfg_nxt.gain_y        = cfg_data[31:0];
        sgw_pkg::REG_HALF_EXPONENT: cfg_nxt.half_exponent = cfg_data[15:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_angle     <= sgw_pkg::COS_RESET;
      cfg_r.sin_angle     <= sgw_pkg::SIN_RESET;
      cfg_r.gain_x        <= sgw_pkg::GAIN_RESET;
      cfg_r.gain_y        <= sgw_pkg::GAIN_RESET;
      cfg_r.half_exponent <= sgw_pkg::HALF_EXP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front rotates the point and builds the squared radius.
  sgw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_x_pos (in_x_pos),
    .in_y_pos (in_y_pos),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_r2   (front_r2)
  );

  // The short queue between the parts lets each one stall on its own.
  sgw_fifo #(
    .WIDTH (sgw_pkg::R2_W),
    .DEPTH (sgw_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (front_r2),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_r2)
  );

  // The back turns the squared radius into the weight.
  sgw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mid_empty  (mid_empty),
    .mid_pop    (mid_pop),
    .mid_r2     (mid_r2),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_weight (res_weight)
  );

  // Results wait here until the consumer completes the transfer.
  sgw_fifo #(
    .WIDTH (sgw_pkg::WEIGHT_W),
    .DEPTH (sgw_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_weight),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_weight)
  );

endmodule

`default_nettype wire
